FILE: design/bcba_pkg.sv
// shared types, codes and widths of the chained bump allocator
package bcba_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BYTES_W  = 25;
  localparam int unsigned ALIGNED_W = 26;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned BLOCK_W  = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ACNT_W   = 32;
  localparam int unsigned STAT_W   = 31;
  localparam int unsigned STATUS_W = 2;

  // reset value of the block size register
  localparam logic [BYTES_W-1:0] BLOCK_SIZE_RESET = 25'd65536;

  // saturation limits
  localparam logic [STAT_W-1:0] SAT31 = '1;
  localparam logic [ACNT_W-1:0] SAT32 = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BIG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [BYTES_W-1:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  granted_block;
    logic [OFFSET_W-1:0] granted_offset;
    logic [BYTES_W-1:0]  granted_bytes;
    logic [ACNT_W-1:0]   frame_alloc_count;
    logic [STAT_W-1:0]   frame_bytes_used;
    logic [STAT_W-1:0]   peak_bytes_used;
    logic [COUNT_W-1:0]  blocks_open;
    logic [STAT_W-1:0]   total_capacity;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_ROUND,
    S_EXEC,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic div_step;
    logic round;
    logic exec;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_align;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/bcba_align.sv
// round-up of a request size to the alignment by reciprocal multiplication
module bcba_align #(
  parameter int unsigned ALIGN_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step,
  input  logic                          round,
  input  logic [bcba_pkg::BYTES_W-1:0]  value,
  output logic                          last,
  output logic [bcba_pkg::ALIGNED_W-1:0] aligned
);
  import bcba_pkg::*;

  // (value + align - 1) / align as a multiply by a scaled reciprocal,
  // exact for every numerator below 2**NW
  localparam int unsigned NW = ALIGNED_W;
  localparam int unsigned LW = $clog2(ALIGN_BYTES);
  localparam int unsigned SH = NW + LW;
  localparam int unsigned MW = NW + 1;
  localparam int unsigned PW = NW + MW;
  localparam int unsigned AW = LW + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
  localparam logic [MW-1:0] RECIP    = MW'(RECIP_L);
  localparam logic [AW-1:0] ALIGN_V  = AW'(ALIGN_BYTES);
  localparam logic [NW-1:0] ALIGN_M1 = NW'(ALIGN_BYTES - 1);

  logic [BYTES_W-1:0]   val_r, val_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [ALIGNED_W-1:0] aligned_r, aligned_nxt;
  logic [NW-1:0]        num;
  logic [PW-1:0]        prod;
  logic [NW+AW-1:0]     scaled;

  // capture the request, then one multiply for the quotient
  always_comb begin
    num     = NW'(val_r) + ALIGN_M1;
    prod    = PW'(num) * PW'(RECIP);
    val_nxt = start ? value : val_r;
    quo_nxt = step ? NW'(prod >> SH) : quo_r;
  end

  // quotient times the alignment gives the rounded size
  always_comb begin
    scaled      = (NW + AW)'(quo_r) * (NW + AW)'(ALIGN_V);
    aligned_nxt = round ? ALIGNED_W'(scaled) : aligned_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r     <= '0;
      aligned_r <= '0;
    end else begin
      quo_r     <= quo_nxt;
      aligned_r <= aligned_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign last    = step;
  assign aligned = aligned_r;

endmodule

FILE: design/bcba_datapath.sv
// allocator state, placement logic, statistics and result register
module bcba_datapath #(
  parameter int unsigned ALIGN_BYTES = 256,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcba_pkg::cmd_t               cmd,
  output bcba_pkg::stat_t              stat,
  input  bcba_pkg::in_item_t           in_data,
  input  logic                         cfg_wr_en,
  input  logic [bcba_pkg::BYTES_W-1:0] cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bcba_pkg::out_item_t          out_data
);
  import bcba_pkg::*;

  localparam logic [COUNT_W-1:0] MAXB = COUNT_W'(MAX_BLOCKS);

  in_item_t             item_r;
  logic [BYTES_W-1:0]   bs_r;
  logic [COUNT_W-1:0]   cur_r, cur_nxt;
  logic [BYTES_W-1:0]   fill_r, fill_nxt;
  logic [COUNT_W-1:0]   open_r, open_nxt;
  logic                 exh_r, exh_nxt;
  logic [ACNT_W-1:0]    acnt_r, acnt_nxt;
  logic [STAT_W-1:0]    bcnt_r, bcnt_nxt;
  logic [STAT_W-1:0]    peak_r, peak_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [BLOCK_W-1:0]   gblk_r, gblk_nxt;
  logic [OFFSET_W-1:0]  goff_r, goff_nxt;
  logic [BYTES_W-1:0]   gbytes_r, gbytes_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [ALIGNED_W-1:0] aligned;
  logic                 div_last;
  logic [BYTES_W-1:0]   goff;
  logic [COUNT_W-1:0]   blk;
  logic [COUNT_W-1:0]   blk_inc;
  logic                 placed;
  logic                 fits;
  logic [ACNT_W-1:0]    bsum;
  logic [ACNT_W-1:0]    cap_full;

  // alignment unit
  bcba_align #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_align (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.capture),
    .step    (cmd.div_step),
    .round   (cmd.round),
    .value   (in_data.request_bytes),
    .last    (div_last),
    .aligned (aligned)
  );

  // placement and state update of one item
  always_comb begin
    cur_nxt    = cur_r;
    fill_nxt   = fill_r;
    open_nxt   = open_r;
    exh_nxt    = exh_r;
    acnt_nxt   = acnt_r;
    bcnt_nxt   = bcnt_r;
    peak_nxt   = peak_r;
    status_nxt = ST_OK;
    gblk_nxt   = '0;
    goff_nxt   = '0;
    gbytes_nxt = '0;
    goff       = '0;
    blk        = cur_r;
    blk_inc    = cur_r + 1'b1;
    placed     = 1'b0;
    fits       = ((ALIGNED_W + 1)'(fill_r) + (ALIGNED_W + 1)'(aligned))
                 <= (ALIGNED_W + 1)'(bs_r);
    bsum       = ACNT_W'(bcnt_r) + ACNT_W'(aligned);
    unique case (item_r.operation)
      OP_ALLOC: begin
        if (item_r.request_bytes == '0) begin
          status_nxt = ST_ZERO;
        end else if (aligned > ALIGNED_W'(bs_r)) begin
          status_nxt = ST_BIG;
        end else if (exh_r) begin
          status_nxt = ST_OUT;
        end else begin
          // try the current block, then the next open one
          if (cur_r < open_r) begin
            if (fits) begin
              goff   = fill_r;
              placed = 1'b1;
            end else begin
              blk = blk_inc;
              if (blk_inc < open_r) begin
                placed = 1'b1;
              end
            end
          end
          // open a new block or run out
          if (!placed) begin
            blk = open_r;
            if (open_r < MAXB) begin
              open_nxt = open_r + 1'b1;
              placed   = 1'b1;
            end else begin
              exh_nxt    = 1'b1;
              status_nxt = ST_OUT;
            end
          end
          cur_nxt = blk;
          if (placed) begin
            fill_nxt   = BYTES_W'(ALIGNED_W'(goff) + aligned);
            gblk_nxt   = blk[BLOCK_W-1:0];
            goff_nxt   = goff[OFFSET_W-1:0];
            gbytes_nxt = item_r.request_bytes;
            acnt_nxt   = (acnt_r == SAT32) ? acnt_r : acnt_r + 1'b1;
            bcnt_nxt   = (bsum > ACNT_W'(SAT31)) ? SAT31 : bsum[STAT_W-1:0];
          end
        end
      end
      OP_FRAME: begin
        peak_nxt = (bcnt_r > peak_r) ? bcnt_r : peak_r;
        cur_nxt  = '0;
        fill_nxt = '0;
        acnt_nxt = '0;
        bcnt_nxt = '0;
        exh_nxt  = 1'b0;
      end
      OP_RELEASE: begin
        open_nxt = '0;
        cur_nxt  = '0;
        fill_nxt = '0;
        acnt_nxt = '0;
        bcnt_nxt = '0;
        exh_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // result register with capacity product
  always_comb begin
    cap_full      = ACNT_W'(open_r) * ACNT_W'(bs_r);
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.status            = status_r;
      out_data_nxt.granted_block     = gblk_r;
      out_data_nxt.granted_offset    = goff_r;
      out_data_nxt.granted_bytes     = gbytes_r;
      out_data_nxt.frame_alloc_count = acnt_r;
      out_data_nxt.frame_bytes_used  = bcnt_r;
      out_data_nxt.peak_bytes_used   = peak_r;
      out_data_nxt.blocks_open       = open_r;
      out_data_nxt.total_capacity    = (cap_full > ACNT_W'(SAT31)) ? SAT31
                                       : cap_full[STAT_W-1:0];
    end
  end

  // allocator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= BLOCK_SIZE_RESET;
      cur_r       <= '0;
      fill_r      <= '0;
      open_r      <= COUNT_W'(1);
      exh_r       <= 1'b0;
      acnt_r      <= '0;
      bcnt_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bs_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        cur_r  <= cur_nxt;
        fill_r <= fill_nxt;
        open_r <= open_nxt;
        exh_r  <= exh_nxt;
        acnt_r <= acnt_nxt;
        bcnt_r <= bcnt_nxt;
        peak_r <= peak_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and grant payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      gblk_r   <= gblk_nxt;
      goff_r   <= goff_nxt;
      gbytes_r <= gbytes_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign stat.need_align = (in_data.operation == OP_ALLOC) && (in_data.request_bytes != '0);
  assign stat.div_last   = div_last;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

FILE: design/bcba_ctrl.sv
// sequencing state machine of the allocator
module bcba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bcba_pkg::stat_t stat,
  output bcba_pkg::cmd_t  cmd
);
  import bcba_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_align ? S_DIVIDE : S_EXEC;
        end
      end
      S_DIVIDE: begin
        if (stat.div_last) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/block_chained_bump_allocator_top.sv
// allocate: after acceptance runs divide, round, exec and emit; new items only in idle
// end of frame, release all, unused code, zero-size allocate: straight to exec, then emit
// an allocate adds the reciprocal multiply and the round-up multiply, in a state each
// with the result register full, emit waits in its state until the old result is taken
// synchronous active-low reset: block size 65536, one block open, all counters zero
// top level of the chained bump allocator
module block_chained_bump_allocator_top #(
  parameter int unsigned ALIGN_BYTES = 256,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bcba_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bcba_pkg::out_item_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [bcba_pkg::BYTES_W-1:0] cfg_wr_data
);
  import bcba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  bcba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // allocator datapath
  bcba_datapath #(
    .ALIGN_BYTES (ALIGN_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: dv/block_chained_bump_allocator_top_test.sv
// testbench of the chained bump allocator: directed, zero block size, exhaustion, stall and random phases
module block_chained_bump_allocator_top_test;
  import bcba_pkg::*;

  localparam int unsigned ALIGN_BYTES   = 256;
  localparam int unsigned MAX_BLOCKS    = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [BYTES_W-1:0] MAX_REQ = 25'd16777216;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 128;
  localparam longint unsigned RUN_LIMIT = 64'd12 * 64'd1500000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  in_item_t            in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en   = 1'b0;
  logic [BYTES_W-1:0]  cfg_wr_data = '0;

  // random idling on both sides, and the receiver hold-off request
  bit          idle_on   = 1'b1;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned mismatches = 0;
  out_item_t   expected_grants[$];

  // allocator state as the predictor sees it
  logic [BYTES_W-1:0] blk_size      = BLOCK_SIZE_RESET;
  logic [6:0]         cur_blk       = '0;
  logic [BYTES_W-1:0] cur_fill      = '0;
  logic [6:0]         blk_open      = 7'd1;
  logic               out_of_blocks = 1'b0;
  logic [ACNT_W-1:0]  grant_count   = '0;
  logic [STAT_W-1:0]  frame_bytes   = '0;
  logic [STAT_W-1:0]  peak_bytes    = '0;

  block_chained_bump_allocator_top #(
    .ALIGN_BYTES(ALIGN_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // round up to the next multiple of the alignment
  function automatic logic [63:0] align_up(logic [63:0] v);
    return ((v + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  // next state of the allocator and the result of one item
  function automatic out_item_t predict_allocator(in_item_t it);
    out_item_t   r;
    logic [63:0] need;
    logic [63:0] off;
    logic [63:0] sum;
    logic [63:0] cap;
    bit          placed;
    r = '0;
    case (it.operation)
      OP_ALLOC: begin
        need = align_up(64'(it.request_bytes));
        if (it.request_bytes == 0) begin
          r.status = ST_ZERO;
        end else if (need > blk_size) begin
          r.status = ST_BIG;
        end else if (out_of_blocks) begin
          r.status = ST_OUT;
        end else begin
          placed = 1'b0;
          off = '0;
          // try the current block, then the next open one
          if (cur_blk < blk_open) begin
            off = align_up(64'(cur_fill));
            if (off + need <= blk_size) begin
              placed = 1'b1;
            end else begin
              cur_blk = cur_blk + 1'b1;
              off = '0;
              if (cur_blk < blk_open) placed = 1'b1;
            end
          end
          // open a fresh block or give up until the frame ends
          if (!placed) begin
            if (blk_open < MAX_BLOCKS) begin
              blk_open = blk_open + 1'b1;
              cur_blk = blk_open - 1'b1;
              off = '0;
              placed = 1'b1;
            end else begin
              cur_blk = blk_open;
              out_of_blocks = 1'b1;
              r.status = ST_OUT;
            end
          end
          if (placed) begin
            cur_fill = BYTES_W'(off + need);
            r.granted_block  = cur_blk[BLOCK_W-1:0];
            r.granted_offset = off[OFFSET_W-1:0];
            r.granted_bytes  = it.request_bytes;
            if (grant_count != SAT32) grant_count = grant_count + 1'b1;
            sum = 64'(frame_bytes) + need;
            frame_bytes = (sum > SAT31) ? SAT31 : sum[STAT_W-1:0];
          end
        end
      end
      OP_FRAME: begin
        if (frame_bytes > peak_bytes) peak_bytes = frame_bytes;
        cur_blk = '0;
        cur_fill = '0;
        grant_count = '0;
        frame_bytes = '0;
        out_of_blocks = 1'b0;
      end
      OP_RELEASE: begin
        blk_open = '0;
        cur_blk = '0;
        cur_fill = '0;
        grant_count = '0;
        frame_bytes = '0;
        out_of_blocks = 1'b0;
      end
      default: begin
      end
    endcase
    cap = 64'(blk_open) * 64'(blk_size);
    r.frame_alloc_count = grant_count;
    r.frame_bytes_used  = frame_bytes;
    r.peak_bytes_used   = peak_bytes;
    r.blocks_open       = blk_open;
    r.total_capacity    = (cap > SAT31) ? SAT31 : cap[STAT_W-1:0];
    return r;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch in %0s: got %0d, want %0d, at %0t", what, got, want, $time);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.granted_block !== want.granted_block)
      report_mismatch("granted_block", got.granted_block, want.granted_block);
    if (got.granted_offset !== want.granted_offset)
      report_mismatch("granted_offset", got.granted_offset, want.granted_offset);
    if (got.granted_bytes !== want.granted_bytes)
      report_mismatch("granted_bytes", got.granted_bytes, want.granted_bytes);
    if (got.frame_alloc_count !== want.frame_alloc_count)
      report_mismatch("frame_alloc_count", got.frame_alloc_count, want.frame_alloc_count);
    if (got.frame_bytes_used !== want.frame_bytes_used)
      report_mismatch("frame_bytes_used", got.frame_bytes_used, want.frame_bytes_used);
    if (got.peak_bytes_used !== want.peak_bytes_used)
      report_mismatch("peak_bytes_used", got.peak_bytes_used, want.peak_bytes_used);
    if (got.blocks_open !== want.blocks_open)
      report_mismatch("blocks_open", got.blocks_open, want.blocks_open);
    if (got.total_capacity !== want.total_capacity)
      report_mismatch("total_capacity", got.total_capacity, want.total_capacity);
  endtask

  // result side: compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) report_mismatch("result with none pending", 1, 0);
      else check_result(out_data, expected_grants.pop_front());
    end
  end

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_on || ($urandom_range(99) >= 21);
    end
  end

  // offer one item, with an occasional gap first, and predict it once taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTES_W-1:0] req);
    in_item_t    it;
    out_item_t   want;
    int unsigned gap;
    it.operation = op;
    it.request_bytes = req;
    gap = 0;
    if (idle_on && $urandom_range(99) < 21)
      gap = ($urandom_range(99) < 70) ? $urandom_range(8, 1) : $urandom_range(45, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    want = predict_allocator(it);
    expected_grants.insert(expected_grants.size(), want);
  endtask

  // sender stops until every result is back, then lets the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_block_size(input logic [BYTES_W-1:0] bs);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bs;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    blk_size = bs;
  endtask

  // request sizes spread around the block size
  function automatic logic [BYTES_W-1:0] pick_request(logic [BYTES_W-1:0] bs);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 9 && bs < MAX_REQ) return BYTES_W'($urandom_range(MAX_REQ, bs + 1));
    if (sel < 25)
      return BYTES_W'($urandom_range(bs, (bs > ALIGN_BYTES) ? bs - ALIGN_BYTES : 1));
    if (sel < 35) return BYTES_W'(ALIGN_BYTES * $urandom_range(bs / ALIGN_BYTES, 1));
    if (sel < 70) return BYTES_W'($urandom_range((bs >= 32) ? bs / 16 : 1, 1));
    return BYTES_W'($urandom_range(bs, 1));
  endfunction

  // operation mix, rates in items per thousand
  function automatic logic [OP_W-1:0] pick_operation(int unsigned frame_pm,
                                                      int unsigned release_pm);
    int unsigned sel;
    sel = $urandom_range(999);
    if (sel < frame_pm) return OP_FRAME;
    if (sel < frame_pm + release_pm) return OP_RELEASE;
    if (sel < frame_pm + release_pm + 10) return OP_UNUSED;
    return OP_ALLOC;
  endfunction

  // size extremes, check order, unused code, rewind and release
  task automatic test_directed();
    send_item(OP_ALLOC, 0);
    send_item(OP_ALLOC, 1);
    send_item(OP_ALLOC, 255);
    send_item(OP_ALLOC, 257);
    send_item(OP_ALLOC, 65536);
    send_item(OP_ALLOC, 65537);
    send_item(OP_ALLOC, MAX_REQ);
    send_item(OP_UNUSED, MAX_REQ);
    send_item(OP_FRAME, 0);
    send_item(OP_ALLOC, 100);
    send_item(OP_RELEASE, 0);
    send_item(OP_ALLOC, 100);
    send_item(OP_FRAME, 0);
    wait_drained();
    set_block_size(MAX_REQ);
    send_item(OP_ALLOC, MAX_REQ);
    send_item(OP_ALLOC, 1);
    send_item(OP_ALLOC, MAX_REQ - 1'b1);
    send_item(OP_FRAME, 0);
    send_item(OP_RELEASE, 0);
    wait_drained();
  endtask

  // block size of zero rejects every nonzero request
  task automatic test_zero_block_size();
    set_block_size('0);
    send_item(OP_ALLOC, 1);
    send_item(OP_ALLOC, 0);
    send_item(OP_ALLOC, MAX_REQ);
    send_item(OP_ALLOC, BYTES_W'(ALIGN_BYTES));
    send_item(OP_FRAME, 0);
    wait_drained();
  endtask

  // open every block, run out, then refill the kept chain after a rewind
  task automatic test_exhaustion();
    set_block_size(BYTES_W'(ALIGN_BYTES));
    send_item(OP_RELEASE, BYTES_W'($urandom_range(MAX_REQ)));
    for (int i = 0; i < MAX_BLOCKS + 3; i++)
      send_item(OP_ALLOC, BYTES_W'($urandom_range(ALIGN_BYTES, 1)));
    send_item(OP_ALLOC, 0);
    send_item(OP_ALLOC, BYTES_W'(ALIGN_BYTES + 1));
    send_item(OP_ALLOC, 1);
    send_item(OP_FRAME, 0);
    for (int i = 0; i < MAX_BLOCKS + 2; i++)
      send_item(OP_ALLOC, BYTES_W'($urandom_range(ALIGN_BYTES, 1)));
    send_item(OP_FRAME, 0);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    logic [OP_W-1:0] op;
    set_block_size(25'd1024);
    idle_on = 1'b0;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 40; i++) begin
      op = pick_operation(40, 10);
      send_item(op, (op == OP_ALLOC) ? pick_request(blk_size)
                                     : BYTES_W'($urandom_range(MAX_REQ)));
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  // random phases over several block sizes, state carried across size changes
  task automatic test_random_phases();
    logic [BYTES_W-1:0] bs;
    logic [OP_W-1:0]    op;
    int unsigned        frame_pm;
    int unsigned        release_pm;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: bs = 25'd256;
        1: bs = 25'd768;
        2: bs = 25'd1024;
        3: bs = 25'd512;
        4: bs = 25'd4096;
        5: bs = BYTES_W'($urandom_range(8192, 256));
        6: bs = 25'd65536;
        7: bs = MAX_REQ;
        default: bs = BYTES_W'($urandom_range(MAX_REQ, 256));
      endcase
      set_block_size(bs);
      // one phase without any idling on either side
      idle_on = (p != 2);
      frame_pm = $urandom_range(60, 4);
      release_pm = $urandom_range(25, 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = pick_operation(frame_pm, release_pm);
        send_item(op, (op == OP_ALLOC) ? pick_request(bs)
                                       : BYTES_W'($urandom_range(MAX_REQ)));
      end
      wait_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_block_size();
    test_exhaustion();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (expected_grants.size() != 0)
      report_mismatch("results never delivered", expected_grants.size(), 0);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule
